// File: src/ddo_pkg.sv
// Shared types, field widths, constants and the arctangent table of the odometry block.
package ddo_pkg;

  localparam int ANGLE_BITS_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int COUNT_W    = 32;
  localparam int DEG_IN_W   = 9;
  localparam int DIST_OUT_W = 31;
  localparam int DEG_OUT_W  = 9;
  localparam int RAD_OUT_W  = 3;
  localparam int POS_OUT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = 32;
  localparam int ATAN_IDX_W = 5;

  localparam int DEG_TURN = 360;
  localparam int DEG_MAX  = 359;
  localparam int RAD_MAX  = 6;

  // ceil(2^RECIP_SHIFT / 360): exact floor(x / 360) for any x below 360 * 360.
  localparam int          RECIP_SHIFT = 26;
  localparam logic [31:0] RECIP_360   =
    32'(((64'd1 << RECIP_SHIFT) + 64'(DEG_MAX)) / 64'(DEG_TURN));

  localparam logic [CFG_DATA_W-1:0] DPC_RESET = 32'd2000000;
  localparam logic [CFG_DATA_W-1:0] TG_RESET  = 32'd22000000;

  localparam logic signed [31:0] CORDIC_K   = 32'sd652032874;
  localparam logic [31:0]        TWO_PI_Q28 = 32'd1686629713;
  localparam logic [46:0]        DIST_MAX   = 47'h7FFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN      = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_SR,
    ST_SC,
    ST_SET,
    ST_ML,
    ST_MR,
    ST_MRW,
    ST_DIFF,
    ST_TA,
    ST_TB,
    ST_HEAD,
    ST_CINIT,
    ST_CORD,
    ST_PA,
    ST_PB,
    ST_PM,
    ST_PP,
    ST_RAD,
    ST_OUT
  } state_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn.
  function automatic logic [31:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// File: src/ddo_chan_if.sv
// Valid/ready channel interfaces for sample items and result items.
interface ddo_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [ddo_pkg::COUNT_W-1:0]  count_left;
  logic signed [ddo_pkg::COUNT_W-1:0]  count_right;
  logic [ddo_pkg::DEG_IN_W-1:0]        heading_degrees_in;

  modport source (output valid, cmd, count_left, count_right, heading_degrees_in,
                  input ready);
  modport sink (input valid, cmd, count_left, count_right, heading_degrees_in,
                output ready);
endinterface

interface ddo_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ddo_pkg::DIST_OUT_W-1:0]       distance_mm;
  logic [ddo_pkg::DEG_OUT_W-1:0]        heading_degrees;
  logic [ddo_pkg::RAD_OUT_W-1:0]        heading_radians;
  logic signed [ddo_pkg::POS_OUT_W-1:0] pos_x_mm;
  logic signed [ddo_pkg::POS_OUT_W-1:0] pos_y_mm;
  logic signed [ddo_pkg::COUNT_W-1:0]   last_count_left;
  logic signed [ddo_pkg::COUNT_W-1:0]   last_count_right;

  modport source (output valid, distance_mm, heading_degrees, heading_radians, pos_x_mm,
                  pos_y_mm, last_count_left, last_count_right, input ready);
  modport sink (input valid, distance_mm, heading_degrees, heading_radians, pos_x_mm,
                pos_y_mm, last_count_left, last_count_right, output ready);
endinterface

// File: src/ddo_mul.sv
// Shared unsigned multiplier with a registered product.
module ddo_mul (
  input  logic                          clk,
  input  logic [ddo_pkg::MUL_W-1:0]     a,
  input  logic [ddo_pkg::MUL_W-1:0]     b,
  output logic [2*ddo_pkg::MUL_W-1:0]   p_r
);

  logic [2*ddo_pkg::MUL_W-1:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// File: src/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: sequencer and datapath.
// Dead-reckoning odometry for a two-wheeled robot. A sample beat (cmd 0) carries the absolute
// encoder counts of both wheels; the block turns the count deltas into wheel travel, advances
// the binary-angle heading, and when the wheels do not run in opposite directions adds the
// mean travel to the distance and rotates it into X/Y with a CORDIC of CORDIC_STEPS steps.
// A set beat (cmd 1) loads the heading in degrees. Every input beat yields exactly one result
// beat. The block takes one item at a time and accepts the next one only after the result of
// the last one is in the output register; a sample whose wheels turn in opposite directions
// skips the CORDIC and the X/Y update. All products go through the single shared 32x32
// multiplier one after another, and the CORDIC does one rotation per cycle. A set beat splits
// 2^ANGLE_BITS / 360 into a whole part and a remainder
// and divides the small remainder product by 360 with a reciprocal multiply, three products
// in a row. A finished result sits in the output register while the next item is accepted.
// Configuration writes take effect at once and must be made while the block is idle.
module differential_drive_odometry #(
  parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_data,
  ddo_in_if.sink                           in_chan,
  ddo_out_if.source                        out_chan
);

  localparam int AB        = ANGLE_BITS;
  localparam int CS        = CORDIC_STEPS;
  localparam int CNT_W     = $clog2(CS);
  localparam int AIW       = ddo_pkg::ATAN_IDX_W;
  localparam int DPW       = AB + ddo_pkg::DEG_OUT_W;
  localparam int MW        = ddo_pkg::MUL_W;
  localparam int CORD_LAST = CS - 1;

  // 2^AB = 360 * SET_Q + SET_R, so deg * 2^AB / 360 = deg * SET_Q + deg * SET_R / 360.
  localparam logic [63:0] TURN_UNITS = 64'd1 << AB;
  localparam logic [31:0] SET_Q      = 32'(TURN_UNITS / 64'(ddo_pkg::DEG_TURN));
  localparam logic [31:0] SET_R      = 32'(TURN_UNITS - 64'(SET_Q) * 64'(ddo_pkg::DEG_TURN));

  function automatic logic [ddo_pkg::POS_OUT_W-1:0] pos_to_mm(input logic signed [47:0] p);
    logic [47:0] pm;
    logic [31:0] sh;
    pm = p[47] ? (48'd0 - p) : p;
    sh = pm[47:16];
    return p[47] ? (32'd0 - sh) : sh;
  endfunction

  // Control state.
  ddo_pkg::state_t    state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               axis_r, axis_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Configuration and odometry state.
  logic [31:0]        dpc_r, dpc_nxt;
  logic [31:0]        tg_r, tg_nxt;
  logic signed [31:0] prev_left_r, prev_left_nxt;
  logic signed [31:0] prev_right_r, prev_right_nxt;
  logic [AB-1:0]      head_r, head_nxt;
  logic [46:0]        trav_r, trav_nxt;
  logic signed [47:0] pos_x_r, pos_x_nxt;
  logic signed [47:0] pos_y_r, pos_y_nxt;

  // Working registers.
  logic signed [31:0] dl_r, dl_nxt;
  logic signed [31:0] dr_r, dr_nxt;
  logic [63:0]        ml_r, ml_nxt;
  logic [63:0]        mr_r, mr_nxt;
  logic [47:0]        diff_r, diff_nxt;
  logic [62:0]        half_r, half_nxt;
  logic               opp_r, opp_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        turn_a_r, turn_a_nxt;
  logic [63:0]        pa_r, pa_nxt;
  logic [49:0]        m_r, m_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic [8:0]         rem_r, rem_nxt;

  // Result register.
  logic [ddo_pkg::DIST_OUT_W-1:0] o_dist_r, o_dist_nxt;
  logic [ddo_pkg::DEG_OUT_W-1:0]  o_deg_r, o_deg_nxt;
  logic [ddo_pkg::RAD_OUT_W-1:0]  o_rad_r, o_rad_nxt;
  logic [ddo_pkg::POS_OUT_W-1:0]  o_px_r, o_px_nxt;
  logic [ddo_pkg::POS_OUT_W-1:0]  o_py_r, o_py_nxt;
  logic signed [31:0]             o_ll_r, o_ll_nxt;
  logic signed [31:0]             o_lr_r, o_lr_nxt;

  // Datapath nets.
  logic [MW-1:0]      mul_a, mul_b;
  logic [2*MW-1:0]    mul_p;
  logic [31:0]        dl_mag, dr_mag;
  logic               ml_nz, mr_nz, l_neg, l_pos, r_neg, r_pos;
  logic [47:0]        tl48, tr48;
  logic [63:0]        half_sum;
  logic [31:0]        step32;
  logic [63:0]        trav_sum;
  logic [31:0]        a32;
  logic [1:0]         quad;
  logic signed [31:0] xs, ys;
  logic [31:0]        atan_cur;
  logic signed [31:0] cos_v, sin_v, trig_v;
  logic               cos_n, sin_n, trig_n, trig_neg;
  logic [31:0]        trig_mag;
  logic [47:0]        half_cap;
  logic [63:0]        pm_sum;
  logic signed [51:0] pos_cur, pos_sum;
  logic signed [47:0] pos_sat;
  logic [8:0]         deg_red;
  logic [DPW-1:0]     deg_prod;
  logic               out_free;

  ddo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign in_chan.ready             = (state_r == ddo_pkg::ST_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.distance_mm      = o_dist_r;
  assign out_chan.heading_degrees  = o_deg_r;
  assign out_chan.heading_radians  = o_rad_r;
  assign out_chan.pos_x_mm         = o_px_r;
  assign out_chan.pos_y_mm         = o_py_r;
  assign out_chan.last_count_left  = o_ll_r;
  assign out_chan.last_count_right = o_lr_r;

  assign out_free = !out_valid_r || out_chan.ready;

  assign dl_mag = dl_r[31] ? (32'd0 - dl_r) : dl_r;
  assign dr_mag = dr_r[31] ? (32'd0 - dr_r) : dr_r;
  assign ml_nz  = (ml_r != 64'd0);
  assign mr_nz  = (mr_r != 64'd0);
  assign l_neg  = dl_r[31] && ml_nz;
  assign l_pos  = !dl_r[31] && ml_nz;
  assign r_neg  = dr_r[31] && mr_nz;
  assign r_pos  = !dr_r[31] && mr_nz;
  assign tl48   = dl_r[31] ? (48'd0 - ml_r[47:0]) : ml_r[47:0];
  assign tr48   = dr_r[31] ? (48'd0 - mr_r[47:0]) : mr_r[47:0];
  assign half_sum = ml_r + mr_r;

  // Bits 16..47 of the heading product: low product plus the low half of the high one.
  assign step32   = {turn_a_r[31:16] + mul_p[15:0], turn_a_r[15:0]};
  assign trav_sum = 64'(trav_r) + 64'(half_r);

  assign a32  = 32'(head_r) << (32 - AB);
  assign quad = a32[31:30];

  assign xs       = x_r >>> cnt_r;
  assign ys       = y_r >>> cnt_r;
  assign atan_cur = ddo_pkg::atan_val(AIW'(cnt_r));

  always_comb begin
    case (quad)
      2'd0: begin
        cos_v = x_r; cos_n = 1'b0; sin_v = y_r; sin_n = 1'b0;
      end
      2'd1: begin
        cos_v = y_r; cos_n = 1'b1; sin_v = x_r; sin_n = 1'b0;
      end
      2'd2: begin
        cos_v = x_r; cos_n = 1'b1; sin_v = y_r; sin_n = 1'b1;
      end
      default: begin
        cos_v = y_r; cos_n = 1'b0; sin_v = x_r; sin_n = 1'b1;
      end
    endcase
  end

  assign trig_v   = axis_r ? cos_v : sin_v;
  assign trig_n   = axis_r ? cos_n : sin_n;
  assign trig_mag = trig_v[31] ? (32'd0 - trig_v) : trig_v;
  // A negated value is negative exactly when the original is strictly positive.
  assign trig_neg = trig_n ? (!trig_v[31] && (trig_v != 32'sd0)) : trig_v[31];
  assign half_cap = (half_r[62:48] != 15'd0) ? 48'hFFFF_FFFF_FFFF : half_r[47:0];

  assign pm_sum  = pa_r + (mul_p >> 16);
  assign pos_cur = axis_r ? 52'(pos_y_r) : 52'(pos_x_r);
  assign pos_sum = (neg_r ^ trig_neg) ? (pos_cur - $signed({2'b00, m_r}))
                                      : (pos_cur + $signed({2'b00, m_r}));
  always_comb begin
    if ((pos_sum[51:47] == 5'b00000) || (pos_sum[51:47] == 5'b11111)) begin
      pos_sat = pos_sum[47:0];
    end else if (pos_sum[51]) begin
      pos_sat = {1'b1, 47'd0};
    end else begin
      pos_sat = {1'b0, {47{1'b1}}};
    end
  end

  assign deg_red  = (in_chan.heading_degrees_in >= 9'(ddo_pkg::DEG_TURN))
                    ? (in_chan.heading_degrees_in - 9'(ddo_pkg::DEG_TURN))
                    : in_chan.heading_degrees_in;
  assign deg_prod = DPW'(head_r) * DPW'(ddo_pkg::DEG_TURN);

  // Multiplier operand selection; the product is read in the state that follows.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ddo_pkg::ST_SQ: begin
        mul_a = MW'(rem_r); mul_b = SET_Q;
      end
      ddo_pkg::ST_SR: begin
        mul_a = MW'(rem_r); mul_b = SET_R;
      end
      ddo_pkg::ST_SC: begin
        mul_a = mul_p[MW-1:0]; mul_b = ddo_pkg::RECIP_360;
      end
      ddo_pkg::ST_ML: begin
        mul_a = dl_mag; mul_b = dpc_r;
      end
      ddo_pkg::ST_MR: begin
        mul_a = dr_mag; mul_b = dpc_r;
      end
      ddo_pkg::ST_TA: begin
        mul_a = diff_r[31:0]; mul_b = tg_r;
      end
      ddo_pkg::ST_TB: begin
        mul_a = {16'd0, diff_r[47:32]}; mul_b = {16'd0, tg_r[15:0]};
      end
      ddo_pkg::ST_PA: begin
        mul_a = half_cap[47:16]; mul_b = trig_mag;
      end
      ddo_pkg::ST_PB: begin
        mul_a = {16'd0, half_cap[15:0]}; mul_b = trig_mag;
      end
      ddo_pkg::ST_RAD, ddo_pkg::ST_OUT: begin
        mul_a = MW'(head_r); mul_b = ddo_pkg::TWO_PI_Q28;
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    axis_nxt       = axis_r;
    cnt_nxt        = cnt_r;
    dpc_nxt        = dpc_r;
    tg_nxt         = tg_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    head_nxt       = head_r;
    trav_nxt       = trav_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    dl_nxt         = dl_r;
    dr_nxt         = dr_r;
    ml_nxt         = ml_r;
    mr_nxt         = mr_r;
    diff_nxt       = diff_r;
    half_nxt       = half_r;
    opp_nxt        = opp_r;
    neg_nxt        = neg_r;
    turn_a_nxt     = turn_a_r;
    pa_nxt         = pa_r;
    m_nxt          = m_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    rem_nxt        = rem_r;
    o_dist_nxt     = o_dist_r;
    o_deg_nxt      = o_deg_r;
    o_rad_nxt      = o_rad_r;
    o_px_nxt       = o_px_r;
    o_py_nxt       = o_py_r;
    o_ll_nxt       = o_ll_r;
    o_lr_nxt       = o_lr_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        ddo_pkg::CFG_DIST_PER_COUNT: dpc_nxt = cfg_data;
        ddo_pkg::CFG_TURN_GAIN:      tg_nxt  = cfg_data;
      endcase
    end

    unique case (state_r)
      ddo_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          cnt_nxt = '0;
          if (in_chan.cmd) begin
            rem_nxt   = deg_red;
            state_nxt = ddo_pkg::ST_SQ;
          end else begin
            dl_nxt         = in_chan.count_left - prev_left_r;
            dr_nxt         = in_chan.count_right - prev_right_r;
            prev_left_nxt  = in_chan.count_left;
            prev_right_nxt = in_chan.count_right;
            state_nxt      = ddo_pkg::ST_ML;
          end
        end
      end
      ddo_pkg::ST_SQ: begin
        state_nxt = ddo_pkg::ST_SR;
      end
      ddo_pkg::ST_SR: begin
        // Whole part: deg * floor(2^AB / 360).
        head_nxt  = mul_p[AB-1:0];
        state_nxt = ddo_pkg::ST_SC;
      end
      ddo_pkg::ST_SC: begin
        state_nxt = ddo_pkg::ST_SET;
      end
      ddo_pkg::ST_SET: begin
        // Remainder part: floor(deg * (2^AB mod 360) / 360) by reciprocal.
        head_nxt  = head_r + AB'(mul_p >> ddo_pkg::RECIP_SHIFT);
        state_nxt = ddo_pkg::ST_RAD;
      end
      ddo_pkg::ST_ML: begin
        state_nxt = ddo_pkg::ST_MR;
      end
      ddo_pkg::ST_MR: begin
        ml_nxt    = mul_p;
        state_nxt = ddo_pkg::ST_MRW;
      end
      ddo_pkg::ST_MRW: begin
        mr_nxt    = mul_p;
        state_nxt = ddo_pkg::ST_DIFF;
      end
      ddo_pkg::ST_DIFF: begin
        diff_nxt  = tl48 - tr48;
        half_nxt  = half_sum[63:1];
        opp_nxt   = (l_neg && r_pos) || (l_pos && r_neg);
        neg_nxt   = l_neg || r_neg;
        state_nxt = ddo_pkg::ST_TA;
      end
      ddo_pkg::ST_TA: begin
        state_nxt = ddo_pkg::ST_TB;
      end
      ddo_pkg::ST_TB: begin
        turn_a_nxt = mul_p[47:16];
        state_nxt  = ddo_pkg::ST_HEAD;
      end
      ddo_pkg::ST_HEAD: begin
        head_nxt = head_r + step32[AB-1:0];
        if (opp_r) begin
          state_nxt = ddo_pkg::ST_RAD;
        end else begin
          trav_nxt  = (trav_sum > 64'(ddo_pkg::DIST_MAX)) ? ddo_pkg::DIST_MAX : trav_sum[46:0];
          state_nxt = ddo_pkg::ST_CINIT;
        end
      end
      ddo_pkg::ST_CINIT: begin
        x_nxt     = ddo_pkg::CORDIC_K;
        y_nxt     = 32'sd0;
        z_nxt     = $signed({2'b00, a32[29:0]});
        cnt_nxt   = '0;
        state_nxt = ddo_pkg::ST_CORD;
      end
      ddo_pkg::ST_CORD: begin
        if (!z_r[31]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - $signed(atan_cur);
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + $signed(atan_cur);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORD_LAST)) begin
          axis_nxt  = 1'b0;
          state_nxt = ddo_pkg::ST_PA;
        end
      end
      ddo_pkg::ST_PA: begin
        state_nxt = ddo_pkg::ST_PB;
      end
      ddo_pkg::ST_PB: begin
        pa_nxt    = mul_p;
        state_nxt = ddo_pkg::ST_PM;
      end
      ddo_pkg::ST_PM: begin
        // floor(half * |trig| / 2^30) from the high and low partial products.
        m_nxt     = pm_sum[63:14];
        state_nxt = ddo_pkg::ST_PP;
      end
      ddo_pkg::ST_PP: begin
        if (axis_r) begin
          pos_y_nxt = pos_sat;
          state_nxt = ddo_pkg::ST_RAD;
        end else begin
          pos_x_nxt = pos_sat;
          axis_nxt  = 1'b1;
          state_nxt = ddo_pkg::ST_PA;
        end
      end
      ddo_pkg::ST_RAD: begin
        state_nxt = ddo_pkg::ST_OUT;
      end
      ddo_pkg::ST_OUT: begin
        if (out_free) begin
          o_dist_nxt    = trav_r[46:16];
          o_deg_nxt     = deg_prod[DPW-1:AB];
          o_rad_nxt     = 3'(mul_p >> (AB + 28));
          o_px_nxt      = pos_to_mm(pos_x_r);
          o_py_nxt      = pos_to_mm(pos_y_r);
          o_ll_nxt      = prev_left_r;
          o_lr_nxt      = prev_right_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ddo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ddo_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      axis_r       <= 1'b0;
      cnt_r        <= '0;
      dpc_r        <= ddo_pkg::DPC_RESET;
      tg_r         <= ddo_pkg::TG_RESET;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      head_r       <= '0;
      trav_r       <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      axis_r       <= axis_nxt;
      cnt_r        <= cnt_nxt;
      dpc_r        <= dpc_nxt;
      tg_r         <= tg_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      head_r       <= head_nxt;
      trav_r       <= trav_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r     <= dl_nxt;
    dr_r     <= dr_nxt;
    ml_r     <= ml_nxt;
    mr_r     <= mr_nxt;
    diff_r   <= diff_nxt;
    half_r   <= half_nxt;
    opp_r    <= opp_nxt;
    neg_r    <= neg_nxt;
    turn_a_r <= turn_a_nxt;
    pa_r     <= pa_nxt;
    m_r      <= m_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    rem_r    <= rem_nxt;
    o_dist_r <= o_dist_nxt;
    o_deg_r  <= o_deg_nxt;
    o_rad_r  <= o_rad_nxt;
    o_px_r   <= o_px_nxt;
    o_py_r   <= o_py_nxt;
    o_ll_r   <= o_ll_nxt;
    o_lr_r   <= o_lr_nxt;
  end

endmodule

// File: src/ddo_chk.sv
// Port-level checker for the odometry block and its bind to the top level.
module ddo_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ddo_pkg::DIST_OUT_W-1:0]    distance_mm,
  input logic [ddo_pkg::DEG_OUT_W-1:0]     heading_degrees,
  input logic [ddo_pkg::RAD_OUT_W-1:0]     heading_radians,
  input logic [ddo_pkg::POS_OUT_W-1:0]     pos_x_mm,
  input logic [ddo_pkg::POS_OUT_W-1:0]     pos_y_mm
);

  // A result beat that is not taken stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk)
    rst_n && out_valid && !out_ready |=> out_valid && $stable(distance_mm) &&
      $stable(heading_degrees) && $stable(pos_x_mm) && $stable(pos_y_mm))
    else $error("result beat dropped or changed while stalled");

  // The block works on one item at a time, so it is busy right after an accepted beat.
  a_busy_after_accept: assert property (@(posedge clk)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while an item is in work");

  // Heading outputs stay inside one turn.
  a_heading_range: assert property (@(posedge clk)
    rst_n && out_valid |-> (heading_degrees <= ddo_pkg::DEG_OUT_W'(ddo_pkg::DEG_MAX)) &&
      (heading_radians <= ddo_pkg::RAD_OUT_W'(ddo_pkg::RAD_MAX)))
    else $error("heading result out of range");

  // After reset the block is idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind differential_drive_odometry ddo_chk u_ddo_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .distance_mm     (out_chan.distance_mm),
  .heading_degrees (out_chan.heading_degrees),
  .heading_radians (out_chan.heading_radians),
  .pos_x_mm        (out_chan.pos_x_mm),
  .pos_y_mm        (out_chan.pos_y_mm)
);

// File: tb/sv/tb_differential_drive_odometry.sv
// Self-checking testbench of the differential-drive odometry block with a bit-exact predictor.
module tb_differential_drive_odometry;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_WAIT      = 14;

  // atan(2^-i) in binary-angle units, 2^32 per turn.
  localparam logic [31:0] ATAN_STEP [0:15] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_LO = -64'sh0000_8000_0000_0000;

  typedef enum logic {
    CMD_SAMPLE      = 1'b0,
    CMD_SET_HEADING = 1'b1
  } odo_cmd_t;

  typedef struct packed {
    odo_cmd_t                           cmd;
    logic signed [ddo_pkg::COUNT_W-1:0] count_left;
    logic signed [ddo_pkg::COUNT_W-1:0] count_right;
    logic [ddo_pkg::DEG_IN_W-1:0]       heading_degrees_in;
  } sample_t;

  typedef struct packed {
    logic [ddo_pkg::DIST_OUT_W-1:0]       distance_mm;
    logic [ddo_pkg::DEG_OUT_W-1:0]        heading_degrees;
    logic [ddo_pkg::RAD_OUT_W-1:0]        heading_radians;
    logic signed [ddo_pkg::POS_OUT_W-1:0] pos_x_mm;
    logic signed [ddo_pkg::POS_OUT_W-1:0] pos_y_mm;
    logic signed [ddo_pkg::COUNT_W-1:0]   last_count_left;
    logic signed [ddo_pkg::COUNT_W-1:0]   last_count_right;
  } report_t;

  class odometry_scoreboard;
    logic [31:0] dist_per_count;
    logic [31:0] turn_gain;
    logic [31:0] prev_left;
    logic [31:0] prev_right;
    logic [31:0] heading;
    logic [63:0] travelled;
    longint      pos_x;
    longint      pos_y;
    report_t     pending_reports[$];
    int          failures;

    function new();
      dist_per_count = ddo_pkg::DPC_RESET;
      turn_gain      = ddo_pkg::TG_RESET;
      prev_left      = '0;
      prev_right     = '0;
      heading        = '0;
      travelled      = '0;
      pos_x          = 0;
      pos_y          = 0;
      failures       = 0;
    endfunction

    function void set_register(logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                               logic [ddo_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        ddo_pkg::CFG_DIST_PER_COUNT: dist_per_count = value;
        ddo_pkg::CFG_TURN_GAIN:      turn_gain = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    // Adds floor(|half * trig| / 2^30) with the combined sign and clamps to 48 signed bits.
    function longint step_position(longint p, bit neg, logic [63:0] half, longint trig);
      logic [63:0] t_mag;
      logic [63:0] m;
      logic [95:0] prod;
      longint      r;
      t_mag = (trig < 0) ? -trig : trig;
      prod  = {32'b0, half} * {32'b0, t_mag};
      m     = prod[93:30];
      if (m > 64'h0004_0000_0000_0000) m = 64'h0004_0000_0000_0000;
      r = (neg != (trig < 0)) ? p - $signed(m) : p + $signed(m);
      if (r > POS_HI) r = POS_HI;
      if (r < POS_LO) r = POS_LO;
      return r;
    endfunction

    function logic signed [31:0] whole_mm(longint p);
      logic [63:0] pm;
      pm = (p < 0) ? -p : p;
      pm = pm >> 16;
      return (p < 0) ? -pm[31:0] : pm[31:0];
    endfunction

    function void note_item(sample_t s);
      logic [31:0] dl, dr, ul, ur;
      logic [63:0] ml, mr, tl, tr, turn, half, w;
      logic [1:0]  quad;
      bit          back_l, back_r, fwd_l, fwd_r;
      int          deg;
      longint      x, y, z, xs, ys, sin_q30, cos_q30;
      report_t     r;
      if (s.cmd == CMD_SET_HEADING) begin
        deg = s.heading_degrees_in;
        if (deg >= ddo_pkg::DEG_TURN) deg -= ddo_pkg::DEG_TURN;
        w = (64'(deg) << 32) / 64'(ddo_pkg::DEG_TURN);
        heading = w[31:0];
      end else begin
        dl = s.count_left - prev_left;
        dr = s.count_right - prev_right;
        ul = dl[31] ? -dl : dl;
        ur = dr[31] ? -dr : dr;
        ml = {32'b0, ul} * {32'b0, dist_per_count};
        mr = {32'b0, ur} * {32'b0, dist_per_count};
        tl = dl[31] ? -ml : ml;
        tr = dr[31] ? -mr : mr;
        // A zero travel counts as neither direction, even for a negative delta.
        back_l = dl[31] && (ml != 0);
        back_r = dr[31] && (mr != 0);
        fwd_l  = !dl[31] && (ml != 0);
        fwd_r  = !dr[31] && (mr != 0);
        turn = (tl - tr) * {32'b0, turn_gain};
        heading = heading + turn[47:16];
        prev_left  = s.count_left;
        prev_right = s.count_right;
        if (!((back_l && fwd_r) || (fwd_l && back_r))) begin
          half = (ml + mr) >> 1;
          if (half > 64'(ddo_pkg::DIST_MAX) - travelled) travelled = 64'(ddo_pkg::DIST_MAX);
          else travelled = travelled + half;
          if (half > 64'hFFFF_FFFF_FFFF) half = 64'hFFFF_FFFF_FFFF;
          // Rotation mode CORDIC on the angle within its quadrant, then quadrant fold.
          quad = heading[31:30];
          z = {34'b0, heading[29:0]};
          x = ddo_pkg::CORDIC_K;
          y = 0;
          for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
              x = x - ys;
              y = y + xs;
              z = z - {32'b0, ATAN_STEP[i]};
            end else begin
              x = x + ys;
              y = y - xs;
              z = z + {32'b0, ATAN_STEP[i]};
            end
          end
          case (quad)
            2'd0: begin
              cos_q30 = x;
              sin_q30 = y;
            end
            2'd1: begin
              cos_q30 = -y;
              sin_q30 = x;
            end
            2'd2: begin
              cos_q30 = -x;
              sin_q30 = -y;
            end
            default: begin
              cos_q30 = y;
              sin_q30 = -x;
            end
          endcase
          pos_x = step_position(pos_x, back_l || back_r, half, sin_q30);
          pos_y = step_position(pos_y, back_l || back_r, half, cos_q30);
        end
      end
      r.distance_mm = travelled[46:16];
      w = {32'b0, heading} * 64'(ddo_pkg::DEG_TURN);
      r.heading_degrees = w[40:32];
      w = {32'b0, heading} * {32'b0, ddo_pkg::TWO_PI_Q28};
      r.heading_radians  = w[62:60];
      r.pos_x_mm         = whole_mm(pos_x);
      r.pos_y_mm         = whole_mm(pos_y);
      r.last_count_left  = prev_left;
      r.last_count_right = prev_right;
      pending_reports.push_back(r);
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.distance_mm !== want.distance_mm) begin
        $error("distance_mm: expected %0d, got %0d", want.distance_mm, got.distance_mm);
        failures++;
      end
      if (got.heading_degrees !== want.heading_degrees) begin
        $error("heading_degrees: expected %0d, got %0d", want.heading_degrees,
               got.heading_degrees);
        failures++;
      end
      if (got.heading_radians !== want.heading_radians) begin
        $error("heading_radians: expected %0d, got %0d", want.heading_radians,
               got.heading_radians);
        failures++;
      end
      if (got.pos_x_mm !== want.pos_x_mm) begin
        $error("pos_x_mm: expected %0d, got %0d", want.pos_x_mm, got.pos_x_mm);
        failures++;
      end
      if (got.pos_y_mm !== want.pos_y_mm) begin
        $error("pos_y_mm: expected %0d, got %0d", want.pos_y_mm, got.pos_y_mm);
        failures++;
      end
      if (got.last_count_left !== want.last_count_left) begin
        $error("last_count_left: expected %0d, got %0d", want.last_count_left,
               got.last_count_left);
        failures++;
      end
      if (got.last_count_right !== want.last_count_right) begin
        $error("last_count_right: expected %0d, got %0d", want.last_count_right,
               got.last_count_right);
        failures++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_data;

  ddo_in_if  in_bus();
  ddo_out_if out_bus();

  differential_drive_odometry u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  odometry_scoreboard sb;
  int unsigned        cycle_count = 0;
  bit                 send_calm = 1'b0;
  bit                 recv_calm = 1'b0;
  logic [31:0]        sent_left;
  logic [31:0]        sent_right;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic sample_t make_item(odo_cmd_t cmd, logic [31:0] lcount,
                                        logic [31:0] rcount, logic [8:0] deg);
    sample_t it;
    it.cmd                = cmd;
    it.count_left         = lcount;
    it.count_right        = rcount;
    it.heading_degrees_in = deg;
    return it;
  endfunction

  // Valid stays high from one beat to the next when no gap is drawn.
  task automatic send_item(input sample_t it);
    int gap;
    if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid              <= 1'b1;
    in_bus.cmd                <= it.cmd;
    in_bus.count_left         <= it.count_left;
    in_bus.count_right        <= it.count_right;
    in_bus.heading_degrees_in <= it.heading_degrees_in;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_item(it);
    if (it.cmd == CMD_SAMPLE) begin
      sent_left  = it.count_left;
      sent_right = it.count_right;
    end
  endtask

  task automatic collect_reports();
    int      gap;
    report_t got;
    forever begin
      if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got.distance_mm      = out_bus.distance_mm;
      got.heading_degrees  = out_bus.heading_degrees;
      got.heading_radians  = out_bus.heading_radians;
      got.pos_x_mm         = out_bus.pos_x_mm;
      got.pos_y_mm         = out_bus.pos_y_mm;
      got.last_count_left  = out_bus.last_count_left;
      got.last_count_right = out_bus.last_count_right;
      sb.check_report(got);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddo_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // Mostly small wheel moves from the last counts; jump_pct sets how often counts are
  // replaced by arbitrary values, which only suits small per-count distances or the end.
  task automatic run_phase(input logic [31:0] dpc, input logic [31:0] gain, input int n_items,
                           input int jump_pct);
    sample_t it;
    int      span, dl, dr, t;
    wait_idle();
    write_reg(ddo_pkg::CFG_DIST_PER_COUNT, dpc);
    write_reg(ddo_pkg::CFG_TURN_GAIN, gain);
    repeat (n_items) begin
      it.heading_degrees_in = $urandom_range(0, 511);
      it.count_left         = $urandom;
      it.count_right        = $urandom;
      if ($urandom_range(0, 7) == 0) begin
        it.cmd = CMD_SET_HEADING;
      end else begin
        it.cmd = CMD_SAMPLE;
        if ($urandom_range(0, 99) >= jump_pct) begin
          case ($urandom_range(0, 2))
            0:       span = 4;
            1:       span = 400;
            default: span = 40000;
          endcase
          dl = int'($urandom_range(0, 2 * span)) - span;
          case ($urandom_range(0, 3))
            0:       dr = dl;
            1:       dr = -dl;
            2:       dr = 0;
            default: dr = int'($urandom_range(0, 2 * span)) - span;
          endcase
          if ($urandom_range(0, 1) == 1) begin
            t  = dl;
            dl = dr;
            dr = t;
          end
          it.count_left  = sent_left + dl;
          it.count_right = sent_right + dr;
        end
      end
      send_item(it);
    end
  endtask

  initial begin
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = ddo_pkg::CFG_DIST_PER_COUNT;
    cfg_data                  = '0;
    in_bus.valid              = 1'b0;
    in_bus.cmd                = CMD_SAMPLE;
    in_bus.count_left         = '0;
    in_bus.count_right        = '0;
    in_bus.heading_degrees_in = '0;
    out_bus.ready             = 1'b0;
    sent_left                 = '0;
    sent_right                = '0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      collect_reports();
    join_none

    // Directed beats at the reset configuration.
    send_item(make_item(CMD_SAMPLE, 0, 0, 0));
    send_item(make_item(CMD_SAMPLE, 360, 360, 300));
    send_item(make_item(CMD_SAMPLE, 720, 360, 0));
    send_item(make_item(CMD_SAMPLE, 700, 380, 511));
    send_item(make_item(CMD_SAMPLE, 600, 300, 0));
    send_item(make_item(CMD_SET_HEADING, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_item(make_item(CMD_SET_HEADING, 32'h8000_0000, 32'h7FFF_FFFF, 90));
    send_item(make_item(CMD_SET_HEADING, 32'h7FFF_FFFF, 32'h8000_0000, 180));
    send_item(make_item(CMD_SET_HEADING, 0, 0, 270));
    send_item(make_item(CMD_SET_HEADING, 0, 0, 359));
    send_item(make_item(CMD_SET_HEADING, 0, 0, 360));
    send_item(make_item(CMD_SET_HEADING, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 511));
    send_item(make_item(CMD_SAMPLE, 960, 660, 0));
    // Large counts are reached with the wheels turning against each other, so the
    // distance does not saturate this early.
    send_item(make_item(CMD_SAMPLE, 2147483000, -2147482000, 0));
    send_item(make_item(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_item(make_item(CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_item(make_item(CMD_SAMPLE, -2147483640, -2147483640, 0));
    // Left delta of exactly minus half the count range.
    send_item(make_item(CMD_SAMPLE, 8, -2147483635, 0));
    send_item(make_item(CMD_SAMPLE, 8, -2147483635, 0));
    send_item(make_item(CMD_SAMPLE, 0, -2147483635, 0));

    run_phase(32'd65536, $urandom_range(1000000, 50000000), 110, 0);
    run_phase(32'd1, 32'hFFFF_FFFF, 110, 50);
    run_phase(32'd0, 32'd0, 80, 25);
    run_phase($urandom_range(0, 4000000), $urandom, 120, 0);
    // Largest distance per count last: the distance saturates for good here.
    run_phase(32'hFFFF_FFFF, $urandom, 130, 50);
    wait_idle();

    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/ddo_pkg.sv
src/ddo_chan_if.sv
src/ddo_mul.sv
src/differential_drive_odometry.sv
src/ddo_chk.sv
tb/sv/tb_differential_drive_odometry.sv
